// ===== rtl/acsa_pkg.sv =====
// Shared types and constants of the ADC sequence channel averager.
package acsa_pkg;

  // Field and storage widths
  localparam int SAMPLE_BITS = 12;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = 5;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int SQS_W       = 28;
  localparam int MEAN_W      = 12;
  localparam int SQM_W       = 24;
  localparam int CH_W        = 3;
  localparam int LEN_W       = 5;
  localparam int SEQ_W       = 48;
  localparam int CFG_W       = 48;
  localparam int DIV_W       = 28;
  localparam int STEP_W      = 5;

  // Register reset values
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;
  localparam logic [SEQ_W-1:0] SEQ_RESET = 48'hB1C50CB1C50C;

  // Register indexes
  typedef enum logic {
    REG_SEQ_LEN  = 1'b0,
    REG_CHAN_SEQ = 1'b1
  } acsa_reg_e;

  // Channel numbers
  localparam logic [CH_W-1:0] CH_PHASE_A = 3'd1;
  localparam logic [CH_W-1:0] CH_PHASE_B = 3'd2;
  localparam logic [CH_W-1:0] CH_PHASE_C = 3'd3;
  localparam logic [CH_W-1:0] CH_BATTERY = 3'd4;
  localparam logic [CH_W-1:0] CH_MOTOR   = 3'd5;

  // Division jobs run at the end of a window, in order
  typedef enum logic [2:0] {
    JOB_A,
    JOB_B,
    JOB_C,
    JOB_BAT,
    JOB_BAT_SQ,
    JOB_MOTOR
  } acsa_job_e;

  // Control states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_WAIT_OUT,
    S_DIV_START,
    S_DIV_WAIT
  } acsa_state_e;

  // Squarer request and response
  typedef struct packed {
    logic                   start;
    logic [SAMPLE_BITS-1:0] a;
  } sqr_req_t;

  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] prod;
  } sqr_rsp_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [CNT_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/acsa_sqr.sv =====
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add.
module acsa_sqr import acsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sqr_req_t req_i,
  output sqr_rsp_t rsp_o
);

  localparam int W  = SAMPLE_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   a_q, a_d;
  logic [2*W-1:0] prod_q, prod_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [W:0]     part_sum;

  // Add the multiplicand to the upper half when the current multiplier bit is set
  assign part_sum = {1'b0, prod_q[2*W-1:W]} + ({1'b0, a_q} & {(W+1){prod_q[0]}});

  // Load, then shift one bit per cycle
  always_comb begin
    a_d    = a_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      prod_d = {{W{1'b0}}, req_i.a};
      cnt_d  = CW'(W);
    end else if (cnt_q != '0) begin
      prod_d = {part_sum, prod_q[W-1:1]};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  // Hold the step count and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Hold the operand and the partial product
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    prod_q <= prod_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

// ===== rtl/acsa_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module acsa_div import acsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  // Load, then produce one quotient bit per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[DIV_W-2:0], fits};
      rem_d  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_d  = cnt_q - STEP_W'(1);
      done_d = (cnt_q == STEP_W'(1));
    end
  end

  // Hold the step count and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Hold the working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== rtl/adc_sequence_channel_averager_top.sv =====
// ADC sequence channel averager: accumulates samples per channel and emits window means.
// Each item is squared bit-serially, then accumulated.
// The last item of a window adds six serial divisions, five of 16 steps and one of 28 steps,
// each started from a handoff state, before the result is shown.
// One item is worked at a time; a finished result waits in the output register while
// further items are taken. Reset restores the register defaults and clears all sums.
module adc_sequence_channel_averager_top import acsa_pkg::*; #(
  parameter int MAX_SAMPLES = 16,
  parameter int CHANNELS    = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [MEAN_W-1:0]      phase_a_o,
  output logic [MEAN_W-1:0]      phase_b_o,
  output logic [MEAN_W-1:0]      phase_c_o,
  output logic [MEAN_W-1:0]      battery_current_o,
  output logic [SQM_W-1:0]       battery_current_sq_mean_o,
  output logic [MEAN_W-1:0]      motor_voltage_o
);

  localparam int POS_W = $clog2(MAX_SAMPLES);
  localparam int SEQ_N = 2 ** POS_W;

  acsa_state_e state_q, state_d;
  acsa_job_e   job_q, job_d;

  logic [LEN_W-1:0]       len_q;
  logic [SEQ_W-1:0]       seq_q;
  logic [POS_W-1:0]       pos_q;
  logic [SUM_W-1:0]       sums_q [CHANNELS];
  logic [CNT_W-1:0]       cnts_q [CHANNELS];
  logic [SQS_W-1:0]       sqs_q;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [CH_W-1:0]        chan_q;
  logic                   chan_ok_q;
  logic                   last_q;
  logic                   out_valid_q;

  logic [CH_W-1:0]        seq_arr [SEQ_N];
  logic [CH_W-1:0]        chan_cur;
  logic                   chan_ok_cur;
  logic [LEN_W-1:0]       len_eff;
  logic                   last_cur;
  logic                   in_acc;
  logic [CH_W-1:0]        job_ch;
  logic [CH_W-1:0]        rd_idx;
  logic [SUM_W-1:0]       rd_sum;
  logic [CNT_W-1:0]       rd_cnt;
  logic                   acc_en;
  logic                   job_done;
  logic                   win_clr;

  sqr_req_t sqr_req;
  sqr_rsp_t sqr_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      seq_q <= SEQ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEQ_LEN:  len_q <= cfg_data_i[LEN_W-1:0];
        REG_CHAN_SEQ: seq_q <= cfg_data_i[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Look up the channel of the current position
  always_comb begin
    for (int k = 0; k < SEQ_N; k++) begin
      seq_arr[k] = seq_q[CH_W*k +: CH_W];
    end
  end
  assign chan_cur    = seq_arr[pos_q];
  assign chan_ok_cur = ({1'b0, chan_cur} < (CH_W+1)'(CHANNELS));

  // Clamp the window length and flag the last sample
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_SAMPLES)) begin
      len_eff = LEN_W'(MAX_SAMPLES);
    end else begin
      len_eff = len_q;
    end
  end
  assign last_cur = ((LEN_W'(pos_q) + LEN_W'(1)) >= len_eff);

  assign in_acc = in_valid_i && !in_stall_o;

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q    <= sample_i;
      chan_q    <= chan_cur;
      chan_ok_q <= chan_ok_cur;
      last_q    <= last_cur;
    end
  end

  // Map each division job to its channel
  always_comb begin
    case (job_q)
      JOB_A:      job_ch = CH_PHASE_A;
      JOB_B:      job_ch = CH_PHASE_B;
      JOB_C:      job_ch = CH_PHASE_C;
      JOB_BAT:    job_ch = CH_BATTERY;
      JOB_BAT_SQ: job_ch = CH_BATTERY;
      JOB_MOTOR:  job_ch = CH_MOTOR;
      default:    job_ch = CH_PHASE_A;
    endcase
  end

  // Share one read port between accumulate and division
  assign rd_idx = (state_q == S_SQR) ? chan_q : job_ch;
  assign rd_sum = sums_q[rd_idx];
  assign rd_cnt = cnts_q[rd_idx];

  // Accumulate sums, counts and the square sum; clear them at window end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        sums_q[k] <= '0;
        cnts_q[k] <= '0;
      end
      sqs_q <= '0;
    end else if (win_clr) begin
      for (int k = 0; k < CHANNELS; k++) begin
        sums_q[k] <= '0;
        cnts_q[k] <= '0;
      end
      sqs_q <= '0;
    end else if (acc_en) begin
      sums_q[chan_q] <= rd_sum + SUM_W'(samp_q);
      cnts_q[chan_q] <= rd_cnt + CNT_W'(1);
      if (chan_q == CH_BATTERY) begin
        sqs_q <= sqs_q + SQS_W'(sqr_rsp.prod);
      end
    end
  end

  // Advance the position, clear it at window end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (win_clr) begin
      pos_q <= '0;
    end else if (state_q == S_SQR && sqr_rsp.done && !last_q) begin
      pos_q <= pos_q + POS_W'(1);
    end
  end

  // Next state and next job
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SQR;
      end
      S_SQR: begin
        if (sqr_rsp.done) state_d = last_q ? S_WAIT_OUT : S_IDLE;
      end
      S_WAIT_OUT: begin
        if (!out_valid_q) state_d = S_DIV_START;
      end
      S_DIV_START: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (job_q)
            JOB_A:      job_d = JOB_B;
            JOB_B:      job_d = JOB_C;
            JOB_C:      job_d = JOB_BAT;
            JOB_BAT:    job_d = JOB_BAT_SQ;
            JOB_BAT_SQ: job_d = JOB_MOTOR;
            default:    job_d = JOB_A;
          endcase
          state_d = (job_q == JOB_MOTOR) ? S_IDLE : S_DIV_START;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_stall_o      = (state_q != S_IDLE);
    sqr_req.start   = 1'b0;
    sqr_req.a       = sample_i;
    div_req.start   = 1'b0;
    div_req.den     = rd_cnt;
    div_req.num     = {rd_sum, {(DIV_W-SUM_W){1'b0}}};
    div_req.steps   = STEP_W'(SUM_W);
    acc_en          = 1'b0;
    job_done        = 1'b0;
    win_clr         = 1'b0;
    if (job_q == JOB_BAT_SQ) begin
      div_req.num   = DIV_W'(sqs_q);
      div_req.steps = STEP_W'(DIV_W);
    end
    case (state_q)
      S_IDLE:      sqr_req.start = in_valid_i;
      S_SQR:       acc_en        = sqr_rsp.done && chan_ok_q;
      S_DIV_START: div_req.start = 1'b1;
      S_DIV_WAIT: begin
        job_done = div_rsp.done;
        win_clr  = div_rsp.done && (job_q == JOB_MOTOR);
      end
      default: ;
    endcase
  end

  // State and job registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= JOB_A;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  acsa_sqr u_sqr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqr_req),
    .rsp_o  (sqr_rsp)
  );

  acsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Drop each quotient into its output register; an empty channel gives zero
  always_ff @(posedge clk_i) begin
    if (job_done) begin
      case (job_q)
        JOB_A:      phase_a_o <= (rd_cnt == '0) ? '0 : div_rsp.quot[MEAN_W-1:0];
        JOB_B:      phase_b_o <= (rd_cnt == '0) ? '0 : div_rsp.quot[MEAN_W-1:0];
        JOB_C:      phase_c_o <= (rd_cnt == '0) ? '0 : div_rsp.quot[MEAN_W-1:0];
        JOB_BAT:    battery_current_o <= (rd_cnt == '0) ? '0 : div_rsp.quot[MEAN_W-1:0];
        JOB_BAT_SQ: battery_current_sq_mean_o <=
                      (rd_cnt == '0) ? '0 : div_rsp.quot[SQM_W-1:0];
        JOB_MOTOR:  motor_voltage_o <= (rd_cnt == '0) ? '0 : div_rsp.quot[MEAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Raise valid at window end, drop it when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (win_clr) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // The window is cleared when its result appears
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (pos_q == '0))
    else $error("position not cleared at window end");

  // The serial units never finish in the same cycle
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqr_rsp.done && div_rsp.done))
    else $error("squarer and divider finished together");

  // A division finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_WAIT))
    else $error("divider result arrived outside its wait state");

  // Output registers are never overwritten while a result is held
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_START) |-> !out_valid_q)
    else $error("division started while a result is still held");

endmodule

// ===== tb/sv/acsa_window_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ADC sequence channel averager: window mean predictor and result compare.
module acsa_window_checker import acsa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [MEAN_W-1:0]      phase_a_i,
  input  logic [MEAN_W-1:0]      phase_b_i,
  input  logic [MEAN_W-1:0]      phase_c_i,
  input  logic [MEAN_W-1:0]      battery_current_i,
  input  logic [SQM_W-1:0]       battery_current_sq_mean_i,
  input  logic [MEAN_W-1:0]      motor_voltage_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int MAX_WINDOW = 16;
  localparam int NUM_CH     = 8;

  typedef struct packed {
    logic [MEAN_W-1:0] phase_a;
    logic [MEAN_W-1:0] phase_b;
    logic [MEAN_W-1:0] phase_c;
    logic [MEAN_W-1:0] battery;
    logic [SQM_W-1:0]  battery_sq;
    logic [MEAN_W-1:0] motor;
  } window_means_t;

  // Shadow of the configuration registers
  logic [LEN_W-1:0] seq_len;
  logic [SEQ_W-1:0] chan_seq;

  // Shadow of the window accumulators
  logic [3:0]       position;
  logic [SUM_W-1:0] ch_sum [NUM_CH];
  logic [CNT_W-1:0] ch_cnt [NUM_CH];
  logic [SQS_W-1:0] sq_sum;

  window_means_t expected_means[$];
  window_means_t want;
  int            errors;

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [SQM_W-1:0] got,
                             input logic [SQM_W-1:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
    end
  endtask

  function automatic logic [MEAN_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                 input logic [CNT_W-1:0] cnt);
    if (cnt == 0) return '0;
    return MEAN_W'(sum / cnt);
  endfunction

  task automatic clear_window();
    position = '0;
    sq_sum   = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      ch_sum[k] = '0;
      ch_cnt[k] = '0;
    end
  endtask

  // Accumulate one item; close the window on its last position
  task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned      eff_len;
    logic [CH_W-1:0]  ch;
    logic [SQS_W-1:0] s_wide;
    window_means_t    m;
    eff_len = (seq_len == 0) ? 1 : (seq_len > MAX_WINDOW) ? MAX_WINDOW : int'(seq_len);
    ch      = chan_seq[CH_W*position +: CH_W];
    s_wide  = SQS_W'(s);
    ch_sum[ch] = ch_sum[ch] + SUM_W'(s);
    ch_cnt[ch] = ch_cnt[ch] + CNT_W'(1);
    if (ch == CH_BATTERY) begin
      sq_sum = sq_sum + s_wide * s_wide;
    end
    if (int'(position) + 1 >= eff_len) begin
      m.phase_a    = mean_of(ch_sum[CH_PHASE_A], ch_cnt[CH_PHASE_A]);
      m.phase_b    = mean_of(ch_sum[CH_PHASE_B], ch_cnt[CH_PHASE_B]);
      m.phase_c    = mean_of(ch_sum[CH_PHASE_C], ch_cnt[CH_PHASE_C]);
      m.battery    = mean_of(ch_sum[CH_BATTERY], ch_cnt[CH_BATTERY]);
      m.battery_sq = (ch_cnt[CH_BATTERY] == 0) ? '0 : SQM_W'(sq_sum / ch_cnt[CH_BATTERY]);
      m.motor      = mean_of(ch_sum[CH_MOTOR], ch_cnt[CH_MOTOR]);
      expected_means.push_back(m);
      clear_window();
    end else begin
      position = position + 4'(1);
    end
  endtask

  // Track register writes, compare results, then predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len  = LEN_RESET;
      chan_seq = SEQ_RESET;
      clear_window();
      expected_means.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SEQ_LEN) begin
          seq_len = cfg_data_i[LEN_W-1:0];
        end else begin
          chan_seq = cfg_data_i[SEQ_W-1:0];
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_means.size() == 0) begin
          report_mismatch("result arrived with no window pending");
        end else begin
          want = expected_means.pop_front();
          check_field("phase_a", SQM_W'(phase_a_i), SQM_W'(want.phase_a));
          check_field("phase_b", SQM_W'(phase_b_i), SQM_W'(want.phase_b));
          check_field("phase_c", SQM_W'(phase_c_i), SQM_W'(want.phase_c));
          check_field("battery_current", SQM_W'(battery_current_i), SQM_W'(want.battery));
          check_field("battery_current_sq_mean", battery_current_sq_mean_i, want.battery_sq);
          check_field("motor_voltage", SQM_W'(motor_voltage_i), SQM_W'(want.motor));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        accumulate_sample(sample_i);
      end
    end
    fail_count_o <= errors;
    pending_o    <= expected_means.size();
  end

endmodule

// ===== tb/sv/tb_adc_sequence_channel_averager_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the ADC sequence channel averager: stimulus, idling and verdict.
module tb_adc_sequence_channel_averager_top;
  import acsa_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int END_CYCLES     = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 600;
  localparam int QUIET_TAIL     = 100;
  localparam logic [SEQ_W-1:0] SEQ_ALL_BATTERY = 48'h924924924924;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  acsa_reg_e              cfg_idx;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] sample_val;
  logic                   out_valid;
  logic                   out_stall;
  logic [MEAN_W-1:0]      phase_a;
  logic [MEAN_W-1:0]      phase_b;
  logic [MEAN_W-1:0]      phase_c;
  logic [MEAN_W-1:0]      battery_current;
  logic [SQM_W-1:0]       battery_current_sq_mean;
  logic [MEAN_W-1:0]      motor_voltage;
  int                     fail_count;
  int                     pending;

  bit tx_gaps;
  bit rx_bursts;
  bit long_hold_arm;
  int quiet_cycles;
  int items_sent;

  adc_sequence_channel_averager_top DUT (
    .clk_i                     (clk),
    .rst_ni                    (rst_n),
    .cfg_we_i                  (cfg_we),
    .cfg_idx_i                 (cfg_idx),
    .cfg_data_i                (cfg_data),
    .in_valid_i                (in_valid),
    .in_stall_o                (in_stall),
    .sample_i                  (sample_val),
    .out_valid_o               (out_valid),
    .out_stall_i               (out_stall),
    .phase_a_o                 (phase_a),
    .phase_b_o                 (phase_b),
    .phase_c_o                 (phase_c),
    .battery_current_o         (battery_current),
    .battery_current_sq_mean_o (battery_current_sq_mean),
    .motor_voltage_o           (motor_voltage)
  );

  acsa_window_checker u_checker (
    .clk_i                     (clk),
    .rst_ni                    (rst_n),
    .cfg_we_i                  (cfg_we),
    .cfg_idx_i                 (cfg_idx),
    .cfg_data_i                (cfg_data),
    .in_valid_i                (in_valid),
    .in_stall_i                (in_stall),
    .sample_i                  (sample_val),
    .out_valid_i               (out_valid),
    .out_stall_i               (out_stall),
    .phase_a_i                 (phase_a),
    .phase_b_i                 (phase_b),
    .phase_c_i                 (phase_c),
    .battery_current_i         (battery_current),
    .battery_current_sq_mean_i (battery_current_sq_mean),
    .motor_voltage_i           (motor_voltage),
    .fail_count_o              (fail_count),
    .pending_o                 (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("adc_sequence_channel_averager_top verification failed");
        $finish;
      end
    end
  end

  // Receiver: one long hold on request, otherwise short random stall bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_arm) begin
        long_hold_arm = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_bursts && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, with an optional gap in front, and hold it until taken
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample_val <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every pending window, then let the last item finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input acsa_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] len_data;
    logic [CFG_W-1:0] seq_data;
    int               n;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= REG_SEQ_LEN;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    sample_val <= '0;
    tx_gaps       = 1'b0;
    rx_bursts     = 1'b0;
    long_hold_arm = 1'b0;
    items_sent    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Full-scale window on the reset pattern; stretch the length past the maximum midway
    repeat (8) push_sample('1);
    wait_idle();
    write_reg(REG_SEQ_LEN, CFG_W'(31));
    repeat (8) push_sample('1);

    // Zero length acts as one; channels without samples give zero means
    wait_idle();
    write_reg(REG_SEQ_LEN, '0);
    write_reg(REG_CHAN_SEQ, SEQ_ALL_BATTERY);
    push_sample('0);
    wait_idle();
    write_reg(REG_CHAN_SEQ, '1);
    push_sample('1);

    // Shrink the length under the current position: the next item closes the window
    wait_idle();
    write_reg(REG_SEQ_LEN, CFG_W'(3));
    write_reg(REG_CHAN_SEQ, CFG_W'(48'hD1));
    push_sample(SAMPLE_BITS'(12'hAAA));
    push_sample(SAMPLE_BITS'(12'h555));
    wait_idle();
    write_reg(REG_SEQ_LEN, CFG_W'(2));
    push_sample(SAMPLE_BITS'(1));

    // Unreported channels 0, 6 and 7 take positions without touching the means
    wait_idle();
    write_reg(REG_SEQ_LEN, CFG_W'(5));
    write_reg(REG_CHAN_SEQ, CFG_W'(48'h1BF0));
    push_sample('1);
    push_sample('1);
    push_sample('1);
    push_sample(SAMPLE_BITS'(7));
    push_sample(SAMPLE_BITS'(3));

    // Back-pressure: hold the receiver off while items keep coming
    wait_idle();
    write_reg(REG_SEQ_LEN, CFG_W'(2));
    write_reg(REG_CHAN_SEQ, SEQ_RESET);
    long_hold_arm = 1'b1;
    repeat (24) push_sample(pick_sample());

    // Random phases, each under a fresh register setting
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      len_data = CFG_W'({$urandom, $urandom});
      case ($urandom_range(0, 7))
        0:       len_data[LEN_W-1:0] = '0;
        1:       len_data[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
        default: len_data[LEN_W-1:0] = LEN_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       seq_data = SEQ_RESET;
        1:       seq_data = SEQ_ALL_BATTERY;
        2:       seq_data = '1;
        3:       seq_data = '0;
        default: seq_data = CFG_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 2))
        0:       write_reg(REG_SEQ_LEN, len_data);
        1:       write_reg(REG_CHAN_SEQ, seq_data);
        default: begin
          write_reg(REG_SEQ_LEN, len_data);
          write_reg(REG_CHAN_SEQ, seq_data);
        end
      endcase
      // Idle on either side in most phases, never in the tail
      tx_gaps   = (items_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      rx_bursts = (items_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(6, 40);
      repeat (n) begin
        push_sample(pick_sample());
        items_sent++;
      end
    end

    // Drain and give the verdict
    tx_gaps   = 1'b0;
    rx_bursts = 1'b0;
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("adc_sequence_channel_averager_top verification clean");
    end else begin
      $display("adc_sequence_channel_averager_top verification failed");
    end
    $finish;
  end

endmodule
